// ===== hdl/pit_pkg.sv =====
// Shared types and constants of the property index table.
package pit_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = 6;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_READ     = 2'd1,
		OP_FIND     = 2'd2,
		OP_VALIDATE = 2'd3
	} pit_op_t;

	// Request as it travels down the chain of cells.
	typedef struct packed {
		pit_op_t            op;
		logic [15:0]        id;
		logic [15:0]        form;
		logic [31:0]        offs;
		logic [15:0]        len;
		logic [POS_W-1:0]   pos;
		logic [CNT_W-1:0]   count;
		logic [31:0]        expect_off;
		logic               hit;
	} pit_pkt_t;

endpackage

// ===== hdl/property_index_table_unit.sv =====
// Top level of the append-only property index table.
//
// Requests arrive on the in_valid/in_ready channel, results leave on the
// out_valid/out_ready channel; each request gives exactly one result.
// The table is a row of TABLE_DEPTH cells, one entry per cell. A request
// enters the first cell and moves one cell per clock unless the chain is
// held; insert is captured by the cell at the fill position, read by the
// cell at the requested position, find by the first filled cell whose id
// matches, and validate keeps a running expected offset as it passes the
// filled cells. The result is registered after the last cell. One request
// is in flight at a time, so the block takes no new request until the
// result of the last one has left the chain.
// A finished result waits in the output register; the next request is
// accepted meanwhile. Should it reach the end of the chain while the
// receiver still stalls, the whole chain holds until the result is taken.
// Reset empties the table (fill count zero) and clears all valid flags;
// entry storage is not cleared and is only ever read once filled.
module property_index_table_unit
	import pit_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [15:0]      key_id,
	input  logic [15:0]      entry_form,
	input  logic [31:0]      entry_offset,
	input  logic [15:0]      entry_length,
	input  logic [POS_W-1:0] position,
	input  logic [31:0]      base_offset,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic             error,
	output logic [15:0]      out_id,
	output logic [15:0]      out_form,
	output logic [31:0]      out_offset,
	output logic [15:0]      out_length,
	output logic [CNT_W-1:0] next_position,
	output logic [CNT_W-1:0] entry_count
);

	logic             busy_q;
	logic [CNT_W-1:0] fill_count_q;
	logic             in_acc;
	logic             adv;
	logic             capture;
	logic             table_full;

	logic             chain_vld [0:TABLE_DEPTH];
	pit_pkt_t         chain_pkt [0:TABLE_DEPTH];
	pit_pkt_t         last;

	logic             res_ok;
	logic             res_err;
	logic             res_fields;
	logic             res_next;
	logic [CNT_W-1:0] res_count;

	logic             out_valid_q;
	logic             ok_q;
	logic             error_q;
	logic [15:0]      out_id_q;
	logic [15:0]      out_form_q;
	logic [31:0]      out_offset_q;
	logic [15:0]      out_length_q;
	logic [CNT_W-1:0] next_position_q;
	logic [CNT_W-1:0] entry_count_q;

	assign in_ready   = !busy_q;
	assign in_acc     = in_valid && in_ready;
	assign table_full = fill_count_q == CNT_W'(TABLE_DEPTH);

	// Hold the chain only when a result is ready and the output slot is still full with the receiver stalling.
	assign adv     = !(chain_vld[TABLE_DEPTH] && out_valid_q && !out_ready);
	assign capture = chain_vld[TABLE_DEPTH] && adv;

	// Build the request at the head of the chain; it carries the fill count
	// seen at acceptance.
	always_comb begin
		chain_vld[0]            = in_acc;
		chain_pkt[0].op         = pit_op_t'(operation);
		chain_pkt[0].id         = key_id;
		chain_pkt[0].form       = entry_form;
		chain_pkt[0].offs       = entry_offset;
		chain_pkt[0].len        = entry_length;
		chain_pkt[0].pos        = position;
		chain_pkt[0].count      = fill_count_q;
		chain_pkt[0].expect_off = base_offset;
		chain_pkt[0].hit        = 1'b0;
	end

	for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
		pit_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.cell_index (CNT_W'(c)),
			.pkt_vld_i  (chain_vld[c]),
			.pkt_i      (chain_pkt[c]),
			.pkt_vld_o  (chain_vld[c+1]),
			.pkt_o      (chain_pkt[c+1])
		);
	end

	assign last = chain_pkt[TABLE_DEPTH];

	// Turn the finished request into a result.
	always_comb begin
		res_ok     = 1'b0;
		res_err    = 1'b0;
		res_fields = 1'b0;
		res_next   = 1'b0;
		res_count  = last.count;
		case (last.op)
			OP_INSERT: begin
				res_ok  = last.count < CNT_W'(TABLE_DEPTH);
				res_err = !res_ok;
				if (res_ok) begin
					res_count = last.count + CNT_W'(1);
				end
			end
			OP_READ: begin
				res_ok     = last.hit;
				res_err    = !last.hit;
				res_fields = last.hit;
				res_next   = last.hit;
			end
			OP_FIND: begin
				res_ok     = last.hit;
				res_fields = last.hit;
			end
			OP_VALIDATE: begin
				res_ok = !last.hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			fill_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (capture) begin
				busy_q <= 1'b0;
			end
			// Advance the fill count as soon as an insert is taken into a table that is not full.
			if (in_acc && (pit_op_t'(operation) == OP_INSERT) && !table_full) begin
				fill_count_q <= fill_count_q + CNT_W'(1);
			end
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			ok_q            <= res_ok;
			error_q         <= res_err;
			out_id_q        <= res_fields ? last.id : 16'd0;
			out_form_q      <= res_fields ? last.form : 16'd0;
			out_offset_q    <= res_fields ? last.offs : 32'd0;
			out_length_q    <= res_fields ? last.len : 16'd0;
			next_position_q <= res_next ? (CNT_W'(last.pos) + CNT_W'(1)) : '0;
			entry_count_q   <= res_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign error         = error_q;
	assign out_id        = out_id_q;
	assign out_form      = out_form_q;
	assign out_offset    = out_offset_q;
	assign out_length    = out_length_q;
	assign next_position = next_position_q;
	assign entry_count   = entry_count_q;

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !chain_vld[TABLE_DEPTH])
		else $error("request at chain end while block idle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_ok_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(ok_q && error_q))
		else $error("result flags both ok and error");

	a_count_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc || (pit_op_t'(operation) != OP_INSERT)) |=> $stable(fill_count_q))
		else $error("fill count moved without an insert");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (busy_q && !in_ready))
		else $error("second request admitted while one is in flight");

endmodule

// ===== hdl/pit_cell.sv =====
// One table cell: holds a single entry and processes the passing request.
module pit_cell
	import pit_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [CNT_W-1:0] cell_index,
	input  logic             pkt_vld_i,
	input  pit_pkt_t         pkt_i,
	output logic             pkt_vld_o,
	output pit_pkt_t         pkt_o
);

	logic [15:0] id_q;
	logic [15:0] form_q;
	logic [31:0] off_q;
	logic [15:0] len_q;
	logic        vld_q;
	pit_pkt_t    pkt_q;
	pit_pkt_t    pkt_d;
	logic        filled;
	logic        wr_en;

	assign filled = cell_index < pkt_i.count;
	assign wr_en  = adv && pkt_vld_i && (pkt_i.op == OP_INSERT) && (pkt_i.count == cell_index);

	always_comb begin
		pkt_d = pkt_i;
		case (pkt_i.op)
			OP_READ: begin
				if (filled && (CMP_W'(pkt_i.pos) == CMP_W'(cell_index))) begin
					pkt_d.hit  = 1'b1;
					pkt_d.id   = id_q;
					pkt_d.form = form_q;
					pkt_d.offs = off_q;
					pkt_d.len  = len_q;
				end
			end
			OP_FIND: begin
				if (!pkt_i.hit && filled && (id_q == pkt_i.id)) begin
					pkt_d.hit  = 1'b1;
					pkt_d.form = form_q;
					pkt_d.offs = off_q;
					pkt_d.len  = len_q;
				end
			end
			OP_VALIDATE: begin
				// hit marks the first broken entry
				if (!pkt_i.hit && filled) begin
					if ((len_q == 16'd0) || (off_q != pkt_i.expect_off)) begin
						pkt_d.hit = 1'b1;
					end else begin
						pkt_d.expect_off = pkt_i.expect_off + {16'd0, len_q};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q   <= pkt_i.id;
			form_q <= pkt_i.form;
			off_q  <= pkt_i.offs;
			len_q  <= pkt_i.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= pkt_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pkt_q <= pkt_d;
		end
	end

	assign pkt_vld_o = vld_q;
	assign pkt_o     = pkt_q;

endmodule

// ===== bench/property_index_table_unit_tb.sv =====
// Self-checking testbench of the property index table: directed and random requests.
module property_index_table_unit_tb;
	import pit_pkg::*;

	// Cycles without any handshake before the run is declared hung. The slowest
	// request takes the chain latency plus the longest sender gap and receiver
	// stall, so this leaves a wide margin.
	localparam int QUIET_LIMIT = 3000;
	// Tail after the last result, so that the cell chain can empty.
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	// Small id pool, so that duplicate ids and first-match finds are common.
	localparam int ID_POOL_MAX = 7;
	// Position of the deliberately zero-length entry; everything before it is
	// laid out back to back so that validate can pass for most of the run.
	localparam int BROKEN_POS = TABLE_DEPTH - 2;

	typedef struct packed {
		pit_op_t          op;
		logic [15:0]      key;
		logic [15:0]      form;
		logic [31:0]      offs;
		logic [15:0]      len;
		logic [POS_W-1:0] pos;
		logic [31:0]      base;
	} pit_request_t;

	typedef struct packed {
		logic             ok;
		logic             err;
		logic [15:0]      id;
		logic [15:0]      form;
		logic [31:0]      offs;
		logic [15:0]      len;
		logic [CNT_W-1:0] next_pos;
		logic [CNT_W-1:0] count;
	} table_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       operation = '0;
	logic [15:0]      key_id = '0;
	logic [15:0]      entry_form = '0;
	logic [31:0]      entry_offset = '0;
	logic [15:0]      entry_length = '0;
	logic [POS_W-1:0] position = '0;
	logic [31:0]      base_offset = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             ok;
	logic             error;
	logic [15:0]      out_id;
	logic [15:0]      out_form;
	logic [31:0]      out_offset;
	logic [15:0]      out_length;
	logic [CNT_W-1:0] next_position;
	logic [CNT_W-1:0] entry_count;

	// Shadow copy of the table, advanced once per accepted request.
	logic [15:0] tbl_id   [TABLE_DEPTH];
	logic [15:0] tbl_form [TABLE_DEPTH];
	logic [31:0] tbl_offs [TABLE_DEPTH];
	logic [15:0] tbl_len  [TABLE_DEPTH];
	int          tbl_fill = 0;

	table_result_t expected_results[$];
	int            sender_idle_pct = 0;
	int            receiver_stall_pct = 0;
	int            quiet_cycles = 0;
	bit            run_failed = 1'b0;

	property_index_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.key_id        (key_id),
		.entry_form    (entry_form),
		.entry_offset  (entry_offset),
		.entry_length  (entry_length),
		.position      (position),
		.base_offset   (base_offset),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.error         (error),
		.out_id        (out_id),
		.out_form      (out_form),
		.out_offset    (out_offset),
		.out_length    (out_length),
		.next_position (next_position),
		.entry_count   (entry_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Work out the result of one request and advance the shadow table. Entries
	// past the fill count are never looked at, so unwritten storage stays unseen.
	function automatic table_result_t apply_to_table(input pit_request_t req);
		table_result_t res;
		logic [31:0]   run_end;
		int            i;
		res = '0;
		case (req.op)
			OP_INSERT: begin
				if (tbl_fill < TABLE_DEPTH) begin
					tbl_id[tbl_fill]   = req.key;
					tbl_form[tbl_fill] = req.form;
					tbl_offs[tbl_fill] = req.offs;
					tbl_len[tbl_fill]  = req.len;
					tbl_fill++;
					res.ok = 1'b1;
				end else begin
					res.err = 1'b1;
				end
			end
			OP_READ: begin
				if (int'(req.pos) < tbl_fill) begin
					res.ok       = 1'b1;
					res.id       = tbl_id[req.pos];
					res.form     = tbl_form[req.pos];
					res.offs     = tbl_offs[req.pos];
					res.len      = tbl_len[req.pos];
					res.next_pos = CNT_W'(req.pos) + CNT_W'(1);
				end else begin
					res.err = 1'b1;
				end
			end
			OP_FIND: begin
				// first match wins, so later duplicates must stay hidden
				for (i = 0; i < tbl_fill; i++) begin
					if (!res.ok && tbl_id[i] == req.key) begin
						res.ok   = 1'b1;
						res.id   = tbl_id[i];
						res.form = tbl_form[i];
						res.offs = tbl_offs[i];
						res.len  = tbl_len[i];
					end
				end
			end
			default: begin
				// running end wraps at 32 bits; a single bad entry spoils it
				res.ok  = 1'b1;
				run_end = req.base;
				for (i = 0; i < tbl_fill; i++) begin
					if (tbl_len[i] == '0 || tbl_offs[i] != run_end)
						res.ok = 1'b0;
					run_end = run_end + 32'(tbl_len[i]);
				end
			end
		endcase
		res.count = CNT_W'(tbl_fill);
		return res;
	endfunction

	// Request of the given kind with every field filled at random; callers
	// override whatever the test cares about.
	function automatic pit_request_t random_request(input pit_op_t op);
		pit_request_t req;
		req.op   = op;
		req.key  = 16'($urandom);
		req.form = 16'($urandom);
		req.offs = $urandom;
		req.len  = 16'($urandom);
		req.pos  = POS_W'($urandom);
		req.base = $urandom;
		return req;
	endfunction

	// Offset at which the next back-to-back entry has to start.
	function automatic logic [31:0] chain_end();
		if (tbl_fill == 0)
			return '0;
		return tbl_offs[tbl_fill-1] + 32'(tbl_len[tbl_fill-1]);
	endfunction

	// Present one request, hold it until the block takes it, then record what
	// should come back. Valid is only dropped when the sender goes idle, so a
	// back-to-back request never sees valid lowered and raised in one step.
	task automatic send_request(input pit_request_t req);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= req.op;
		key_id       <= req.key;
		entry_form   <= req.form;
		entry_offset <= req.offs;
		entry_length <= req.len;
		position     <= req.pos;
		base_offset  <= req.base;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(apply_to_table(req));
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			run_failed = 1'b1;
		end
	endtask

	// Reads of an empty table, a find with nothing stored and validate of an
	// empty table, which must pass whatever the base.
	task automatic test_empty_table();
		pit_request_t req;
		req = random_request(OP_READ);
		req.pos = '0;
		send_request(req);
		req = random_request(OP_READ);
		req.pos = '1;
		send_request(req);
		req = random_request(OP_FIND);
		req.key = '0;
		send_request(req);
		req = random_request(OP_VALIDATE);
		req.base = '1;
		send_request(req);
	endtask

	// First entries at the field extremes; the second one starts where the
	// first wraps past the top of the 32-bit offset range. Then read back,
	// including the position just past the fill count.
	task automatic test_insert_extremes();
		pit_request_t req;
		int           p;
		req = random_request(OP_INSERT);
		req.key  = '1;
		req.form = '1;
		req.offs = 32'hFFFF_FFF0;
		req.len  = 16'h0010;
		send_request(req);
		req = random_request(OP_INSERT);
		req.key  = '0;
		req.form = '0;
		req.offs = '0;
		req.len  = '1;
		send_request(req);
		// duplicate id, so that find has to pick the earlier entry
		req = random_request(OP_INSERT);
		req.key  = '0;
		req.form = 16'h1234;
		req.offs = 32'h0000_FFFF;
		req.len  = 16'h0001;
		send_request(req);
		for (p = 0; p <= 3; p++) begin
			req = random_request(OP_READ);
			req.pos = POS_W'(p);
			send_request(req);
		end
	endtask

	// Find by first match, extreme id and a miss; validate with the right base
	// across the wrap, and with bases that are off.
	task automatic test_find_and_validate();
		pit_request_t req;
		req = random_request(OP_FIND);
		req.key = '0;
		send_request(req);
		req = random_request(OP_FIND);
		req.key = '1;
		send_request(req);
		req = random_request(OP_FIND);
		req.key = 16'h5A5A;
		send_request(req);
		req = random_request(OP_VALIDATE);
		req.base = 32'hFFFF_FFF0;
		send_request(req);
		req = random_request(OP_VALIDATE);
		req.base = 32'hFFFF_FFF1;
		send_request(req);
		req = random_request(OP_VALIDATE);
		req.base = '0;
		send_request(req);
	endtask

	// Mixed traffic. Inserts keep the table back to back until the broken
	// entry, which has zero length but an in-line offset so that only the
	// length check can catch it; once full, inserts carry random content and
	// must all be refused. Reads, finds and validates lean towards hits.
	task automatic test_random_traffic(input int n_requests);
		pit_request_t req;
		int           n;
		int           pick;
		for (n = 0; n < n_requests; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				req = random_request(OP_INSERT);
				if (tbl_fill <= BROKEN_POS) begin
					req.offs = chain_end();
					if ($urandom_range(0, 1) == 0)
						req.key = 16'($urandom_range(0, ID_POOL_MAX));
					if (tbl_fill == BROKEN_POS)
						req.len = '0;
					else if ($urandom_range(0, 3) == 0)
						req.len = 16'($urandom_range(1, 16'hFFFF));
					else
						req.len = 16'($urandom_range(1, 16));
				end
			end else if (pick < 50) begin
				req = random_request(OP_READ);
				if (tbl_fill > 0 && $urandom_range(0, 1) == 0)
					req.pos = POS_W'($urandom_range(0, tbl_fill - 1));
			end else if (pick < 75) begin
				req = random_request(OP_FIND);
				pick = $urandom_range(0, 3);
				if (tbl_fill > 0 && pick < 2)
					req.key = tbl_id[$urandom_range(0, tbl_fill - 1)];
				else if (pick == 2)
					req.key = 16'($urandom_range(0, ID_POOL_MAX));
			end else begin
				req = random_request(OP_VALIDATE);
				pick = $urandom_range(0, 3);
				if (tbl_fill > 0 && pick < 2)
					req.base = tbl_offs[0];
				else if (tbl_fill > 0 && pick == 2)
					req.base = tbl_offs[0] + 32'd1;
			end
			send_request(req);
		end
	endtask

	// Receiver: stall at the rate of the current phase, never otherwise.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

	// Result checker: every accepted result must match the oldest expectation.
	always @(posedge clk) begin
		table_result_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request outstanding, ok %0h error %0h count %0h",
					$time, ok, error, entry_count);
				run_failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				compare_field("ok", 32'(want.ok), 32'(ok));
				compare_field("error", 32'(want.err), 32'(error));
				compare_field("out_id", 32'(want.id), 32'(out_id));
				compare_field("out_form", 32'(want.form), 32'(out_form));
				compare_field("out_offset", want.offs, out_offset);
				compare_field("out_length", 32'(want.len), 32'(out_length));
				compare_field("next_position", 32'(want.next_pos), 32'(next_position));
				compare_field("entry_count", 32'(want.count), 32'(entry_count));
			end
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		// hold reset, then release it on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling on either side
		test_empty_table();
		test_insert_extremes();
		test_find_and_validate();

		// random part: free flow, a lazy sender, a stalling receiver, then both
		test_random_traffic(175);
		sender_idle_pct = 87;
		test_random_traffic(175);
		sender_idle_pct    = 0;
		receiver_stall_pct = 87;
		test_random_traffic(175);
		sender_idle_pct    = 34;
		receiver_stall_pct = 34;
		test_random_traffic(175);

		// drop valid, drain the outstanding results and let the chain settle
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!run_failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
